[rtl/gravity_feedforward_clamp_top_macros.svh]
// Assertion macros shared by the gravity feedforward RTL.
`ifndef GRAVITY_FEEDFORWARD_CLAMP_TOP_MACROS_SVH
`define GRAVITY_FEEDFORWARD_CLAMP_TOP_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define GFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define GFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFC_ASSERT(lbl, clk, rst, prop, msg)
`define GFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/gfc_pkg.sv]
// Types, constants and tables of the gravity feedforward block.
package gfc_pkg;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int CUR_W   = 16;
  localparam int FF_W    = 24;
  localparam int DATA_W  = 24;
  localparam int INDEX_W = 3;

  // Block constants
  localparam logic [15:0] DEFAULT_GRAVITY = 16'd2509;
  localparam logic [14:0] MAX_CURRENT     = 15'd30000;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // Datapath widths
  localparam int XW = 33;  // CORDIC x, y, z in Q30
  localparam int CW = 18;  // cos and sin in Q15
  localparam int WW = 23;  // weight in 1/256 N

  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [XW-1:0] HALF_Q15        = 33'sd16384;
  localparam logic signed [XW-1:0] Z_HALF_PI       = 33'sd1686634496;
  localparam logic [22:0] RECIP_1000 = 23'd4294967;  // floor(2^32 / 1000)
  localparam logic signed [23:0] FF_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] FF_MIN = 24'sh800000;

  localparam logic signed [XW-1:0] ATAN_Q30 [TABLE_LEN] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

  // Register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_MASS    = 3'd0,
    REG_COM_FWD = 3'd1,
    REG_COM_UP  = 3'd2,
    REG_GRAVITY = 3'd3,
    REG_SCALE   = 3'd4,
    REG_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] mass_grams;
    logic signed [15:0] com_forward;
    logic signed [15:0] com_upward;
    logic        [15:0] gravity_accel;
    logic        [23:0] torque_to_current;
    logic        [14:0] current_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mass_grams:        16'd1500,
    com_forward:       16'sd1311,
    com_upward:        16'sd655,
    gravity_accel:     16'd2509,
    torque_to_current: 24'd256,
    current_limit:     15'd3000
  };

  // Side data that rides along the CORDIC stages
  typedef struct packed {
    logic                    neg;
    logic signed [CUR_W-1:0] base;
  } carry_t;

  // Scaled feedforward handed to the clamp stage
  typedef struct packed {
    logic signed [FF_W-1:0]  ff;
    logic signed [CUR_W-1:0] base;
  } ff_item_t;

  // One result item
  typedef struct packed {
    logic signed [CUR_W-1:0] drive;
    logic signed [FF_W-1:0]  ff;
    logic                    clamped;
  } res_t;

endpackage

[rtl/gfc_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface gfc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gfc_pkg::ANGLE_W-1:0]   pitch_angle;
  logic signed [gfc_pkg::CUR_W-1:0]     base_current;

  modport source(output valid, pitch_angle, base_current, input ready);
  modport sink(input valid, pitch_angle, base_current, output ready);
endinterface

interface gfc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gfc_pkg::CUR_W-1:0]  drive_current;
  logic signed [gfc_pkg::FF_W-1:0]   feedforward;
  logic                              clamped;

  modport source(output valid, drive_current, feedforward, clamped, input ready);
  modport sink(input valid, drive_current, feedforward, clamped, output ready);
endinterface

[rtl/gravity_feedforward_clamp_top.sv]
// Top level: configuration registers, pipeline, clamp stage and output skid.
//
// Gravity feedforward for a pitch axis. Each transfer on the item channel
// carries a pitch angle (Q3.13 rad) and a base current command; each one
// gives exactly one transfer on the result channel, in order: the clamped
// drive current, the scaled feedforward and a clamp flag.
// Registers are written through wr_en / wr_index / wr_data, one per cycle;
// the user must write them only while no item is in flight, as the block
// does not enforce it; indexes 6 and 7 are ignored. Throughput: one item
// per cycle while the receiver does not stall. Each item passes through the
// fold stage, one register per CORDIC micro-rotation, the rounding stage,
// seven multiply and round stages, the clamp stage and the output register.
// Reset is synchronous and clears all valid bits and the registers to their
// defaults; item.ready stays low while rst is high.
// When the receiver stalls, one more result lands in a skid register; the
// pipeline then freezes in place and item.ready drops until it drains.
`include "gravity_feedforward_clamp_top_macros.svh"
module gravity_feedforward_clamp_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [gfc_pkg::INDEX_W-1:0]     wr_index,
  input  logic [gfc_pkg::DATA_W-1:0]      wr_data,
  gfc_in_if.sink                          item,
  gfc_out_if.source                       result
);

  gfc_pkg::cfg_t  cfg;
  logic [gfc_pkg::WW-1:0] weight;

  logic           en;
  logic           take;

  logic                               cor_valid;
  logic signed [gfc_pkg::CW-1:0]      cor_cos, cor_sin;
  logic signed [gfc_pkg::CUR_W-1:0]   cor_base;

  logic               sc_valid;
  gfc_pkg::ff_item_t  sc_item;

  logic [14:0]        lim;
  logic signed [24:0] lim_s;
  logic signed [15:0] lim16;
  logic signed [24:0] sum;
  gfc_pkg::res_t      k_next;
  gfc_pkg::res_t      k_r;
  logic               k_v;

  gfc_pkg::res_t      out_r;
  gfc_pkg::res_t      skid_r;
  logic               out_v;
  logic               skid_full;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= gfc_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (gfc_pkg::reg_idx_t'(wr_index))
        gfc_pkg::REG_MASS:    cfg.mass_grams        <= wr_data[15:0];
        gfc_pkg::REG_COM_FWD: cfg.com_forward       <= wr_data[15:0];
        gfc_pkg::REG_COM_UP:  cfg.com_upward        <= wr_data[15:0];
        gfc_pkg::REG_GRAVITY: cfg.gravity_accel     <= wr_data[15:0];
        gfc_pkg::REG_SCALE:   cfg.torque_to_current <= wr_data[23:0];
        gfc_pkg::REG_LIMIT:   cfg.current_limit     <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the skid register holds a result
  assign en         = !skid_full;
  assign item.ready = !skid_full && !rst;
  assign take       = item.valid && item.ready;

  gfc_weight u_weight (
    .clk    (clk),
    .cfg    (cfg),
    .weight (weight)
  );

  gfc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (take),
    .pitch     (item.pitch_angle),
    .base      (item.base_current),
    .out_valid (cor_valid),
    .cos_q15   (cor_cos),
    .sin_q15   (cor_sin),
    .out_base  (cor_base)
  );

  gfc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .weight    (weight),
    .in_valid  (cor_valid),
    .cos_q15   (cor_cos),
    .sin_q15   (cor_sin),
    .in_base   (cor_base),
    .out_valid (sc_valid),
    .out_item  (sc_item)
  );

  // Add the feedforward and clamp to the limit
  assign lim   = (cfg.current_limit == 15'd0) ? gfc_pkg::MAX_CURRENT : cfg.current_limit;
  assign lim_s = $signed({10'b0, lim});
  assign lim16 = $signed({1'b0, lim});
  assign sum   = 25'(sc_item.base) + 25'(sc_item.ff);

  always_comb begin
    k_next.ff      = sc_item.ff;
    k_next.drive   = sum[15:0];
    k_next.clamped = 1'b0;
    if (sum > lim_s) begin
      k_next.drive   = lim16;
      k_next.clamped = 1'b1;
    end else if (sum < -lim_s) begin
      k_next.drive   = -lim16;
      k_next.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (en) begin
      k_v <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r <= k_next;
    end
  end

  // Output register with skid: park a result that arrives during a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v     <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result.ready) begin
        skid_full <= 1'b0;
      end
    end else if (!out_v || result.ready) begin
      out_v <= k_v;
    end else if (k_v) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (result.ready) begin
        out_r <= skid_r;
      end
    end else if (!out_v || result.ready) begin
      if (k_v) begin
        out_r <= k_r;
      end
    end else if (k_v) begin
      skid_r <= k_r;
    end
  end

  assign result.valid         = out_v;
  assign result.drive_current = out_r.drive;
  assign result.feedforward   = out_r.ff;
  assign result.clamped       = out_r.clamped;

  `GFC_ASSERT_ALWAYS(a_no_take_in_reset, clk, rst |-> !item.ready, "item taken during reset")
  `GFC_ASSERT(a_skid_behind_out, clk, rst, skid_full |-> out_v, "skid holds data with output empty")
  `GFC_ASSERT(a_drive_in_limit, clk, rst, out_v |-> (out_r.drive <= lim16 && out_r.drive >= -lim16), "drive current beyond limit")
  `GFC_ASSERT(a_clamp_at_limit, clk, rst, (out_v && out_r.clamped) |-> (out_r.drive == lim16 || out_r.drive == -lim16), "clamp flag without drive at limit")

endmodule

[rtl/gfc_weight.sv]
// Weight from mass and gravity registers: (mass*g + 500) / 1000, three stages.
module gfc_weight (
  input  logic                        clk,
  input  gfc_pkg::cfg_t               cfg,
  output logic [gfc_pkg::WW-1:0]      weight
);

  logic [15:0] grav;
  logic [31:0] num_r;
  logic [31:0] num_d_r;
  logic [54:0] quot_prod;
  logic [gfc_pkg::WW-1:0] quot_r;
  logic [32:0] rem;

  // Pick the default gravity for a zero register
  assign grav = (cfg.gravity_accel == 16'd0) ? gfc_pkg::DEFAULT_GRAVITY : cfg.gravity_accel;

  // Form the rounded numerator
  always_ff @(posedge clk) begin
    num_r <= (32'(cfg.mass_grams) * 32'(grav)) + 32'd500;
  end

  // Estimate the quotient by reciprocal multiply, one low at most
  assign quot_prod = 55'(num_r) * 55'(gfc_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    quot_r  <= quot_prod[54:32];
    num_d_r <= num_r;
  end

  // Correct the estimate from the remainder
  assign rem = 33'(num_d_r) - (33'(quot_r) * 33'd1000);

  always_ff @(posedge clk) begin
    weight <= (rem >= 33'd1000) ? quot_r + 23'd1 : quot_r;
  end

endmodule

[rtl/gfc_cordic.sv]
// Angle fold and pipelined rotation CORDIC giving cos and sin in Q15.
`include "gravity_feedforward_clamp_top_macros.svh"
module gfc_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [gfc_pkg::ANGLE_W-1:0] pitch,
  input  logic signed [gfc_pkg::CUR_W-1:0]   base,
  output logic                              out_valid,
  output logic signed [gfc_pkg::CW-1:0]      cos_q15,
  output logic signed [gfc_pkg::CW-1:0]      sin_q15,
  output logic signed [gfc_pkg::CUR_W-1:0]   out_base
);

  localparam int N = gfc_pkg::NUM_STAGES;
  localparam int XW = gfc_pkg::XW;
  localparam int CW = gfc_pkg::CW;

  logic signed [17:0] a_wrap, a_fold;
  logic               fold_neg;
  logic               fv_r;
  logic signed [XW-1:0] z0_r;
  gfc_pkg::carry_t    fc_r;

  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [XW-1:0] z_r [N-1];
  logic                 v_r [N];
  gfc_pkg::carry_t      cy_r [N];

  logic signed [XW-1:0] x_rnd, y_rnd;
  logic signed [CW-1:0] c_rnd, s_rnd;

  // Wrap into +-pi, then fold into +-pi/2 with a half-turn
  always_comb begin
    a_wrap = 18'(pitch);
    if (a_wrap > 18'sd25736) begin
      a_wrap = a_wrap - 18'sd51472;
    end else if (a_wrap < -18'sd25736) begin
      a_wrap = a_wrap + 18'sd51472;
    end
    a_fold   = a_wrap;
    fold_neg = 1'b0;
    if (a_wrap > 18'sd12868) begin
      a_fold   = a_wrap - 18'sd25736;
      fold_neg = 1'b1;
    end else if (a_wrap < -18'sd12868) begin
      a_fold   = a_wrap + 18'sd25736;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_valid;
    end
  end

  // Capture the folded angle in Q30
  always_ff @(posedge clk) begin
    if (en) begin
      z0_r      <= {a_fold[15:0], 17'b0};
      fc_r.neg  <= fold_neg;
      fc_r.base <= base;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi, zi;
    logic                 vi;
    gfc_pkg::carry_t      ci;

    if (i == 0) begin : g_first
      assign xi = gfc_pkg::CORDIC_GAIN_Q30;
      assign yi = '0;
      assign zi = z0_r;
      assign vi = fv_r;
      assign ci = fc_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = v_r[i-1];
      assign ci = cy_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[XW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
        end
        cy_r[i] <= ci;
      end
    end

    // The last stage leaves no residual angle
    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[XW-1]) begin
            z_r[i] <= zi - gfc_pkg::ATAN_Q30[i];
          end else begin
            z_r[i] <= zi + gfc_pkg::ATAN_Q30[i];
          end
        end
      end
    end
  end

  // Round half up to Q15 and undo the half-turn
  assign x_rnd = x_r[N-1] + gfc_pkg::HALF_Q15;
  assign y_rnd = y_r[N-1] + gfc_pkg::HALF_Q15;
  assign c_rnd = x_rnd[CW+14:15];
  assign s_rnd = y_rnd[CW+14:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q15  <= cy_r[N-1].neg ? -c_rnd : c_rnd;
      sin_q15  <= cy_r[N-1].neg ? -s_rnd : s_rnd;
      out_base <= cy_r[N-1].base;
    end
  end

  `GFC_ASSERT(a_fold_range, clk, rst, fv_r |-> (z0_r <= gfc_pkg::Z_HALF_PI && z0_r >= -gfc_pkg::Z_HALF_PI), "folded angle outside half pi")
  `GFC_ASSERT(a_cos_range, clk, rst, out_valid |-> (cos_q15 <= 18'sd33000 && cos_q15 >= -18'sd33000), "cos out of range")
  `GFC_ASSERT(a_sin_range, clk, rst, out_valid |-> (sin_q15 <= 18'sd33000 && sin_q15 >= -18'sd33000), "sin out of range")

endmodule

[rtl/gfc_scale.sv]
// Torque and current scaling: seven stages from cos/sin to saturated feedforward.
module gfc_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  gfc_pkg::cfg_t                     cfg,
  input  logic [gfc_pkg::WW-1:0]            weight,
  input  logic                              in_valid,
  input  logic signed [gfc_pkg::CW-1:0]      cos_q15,
  input  logic signed [gfc_pkg::CW-1:0]      sin_q15,
  input  logic signed [gfc_pkg::CUR_W-1:0]   in_base,
  output logic                              out_valid,
  output gfc_pkg::ff_item_t                 out_item
);

  localparam int SC_STAGES = 6;

  logic                               v_r [SC_STAGES];
  logic signed [gfc_pkg::CUR_W-1:0]   base_r [SC_STAGES];

  logic signed [15:0] fwd, upw;
  logic signed [33:0] pf_r, pu_r;
  logic signed [34:0] horiz_r;
  logic signed [17:0] h_hi;
  logic        [16:0] h_lo;
  logic signed [23:0] weight_s;
  logic signed [40:0] ph_r;
  logic        [39:0] pl_r;
  logic signed [57:0] prod_r;
  logic signed [58:0] tdiff;
  logic signed [36:0] torque_r;
  logic signed [19:0] t_hi;
  logic        [16:0] t_lo;
  logic        [23:0] scale;
  logic signed [24:0] scale_s;
  logic signed [44:0] fh_r;
  logic        [40:0] fl_r;
  logic signed [61:0] acc;
  logic signed [37:0] ff_wide;
  logic signed [gfc_pkg::FF_W-1:0] ff_sat;

  assign fwd = cfg.com_forward;
  assign upw = cfg.com_upward;

  // Advance valid bits and the base command beside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SC_STAGES; k++) v_r[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < SC_STAGES; k++) v_r[k] <= v_r[k-1];
      out_valid <= v_r[SC_STAGES-1];
    end
  end

  // Stage 7 output: base command and saturated feedforward
  always_ff @(posedge clk) begin
    if (en) begin
      base_r[0] <= in_base;
      for (int k = 1; k < SC_STAGES; k++) base_r[k] <= base_r[k-1];
      out_item.base <= base_r[SC_STAGES-1];
      out_item.ff   <= ff_sat;
    end
  end

  // Stage 1: offset products
  always_ff @(posedge clk) begin
    if (en) begin
      pf_r <= 34'(fwd) * 34'(cos_q15);
      pu_r <= 34'(upw) * 34'(sin_q15);
    end
  end

  // Stage 2: horizontal lever arm
  always_ff @(posedge clk) begin
    if (en) begin
      horiz_r <= 35'(pf_r) + 35'(pu_r);
    end
  end

  // Stage 3: weight times lever arm, split in two partial products
  assign h_hi     = horiz_r[34:17];
  assign h_lo     = horiz_r[16:0];
  assign weight_s = $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= 41'(h_hi) * 41'(weight_s);
      pl_r <= 40'(weight) * 40'(h_lo);
    end
  end

  // Stage 4: join the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (58'(ph_r) <<< 17) + $signed({18'b0, pl_r});
    end
  end

  // Stage 5: negate and round to Q16 torque
  assign tdiff = 59'sd2097152 - 59'(prod_r);

  always_ff @(posedge clk) begin
    if (en) begin
      torque_r <= tdiff[58:22];
    end
  end

  // Stage 6: torque times scale, split in two partial products
  assign scale   = (cfg.torque_to_current == 24'd0) ? 24'd256 : cfg.torque_to_current;
  assign scale_s = $signed({1'b0, scale});
  assign t_hi    = torque_r[36:17];
  assign t_lo    = torque_r[16:0];

  always_ff @(posedge clk) begin
    if (en) begin
      fh_r <= 45'(t_hi) * 45'(scale_s);
      fl_r <= 41'(t_lo) * 41'(scale);
    end
  end

  // Stage 7: join, round, saturate; zero mass drops the feedforward
  assign acc     = (62'(fh_r) <<< 17) + $signed({21'b0, fl_r}) + 62'sd8388608;
  assign ff_wide = acc[61:24];

  always_comb begin
    if (cfg.mass_grams == 16'd0) begin
      ff_sat = '0;
    end else if (ff_wide > 38'(gfc_pkg::FF_MAX)) begin
      ff_sat = gfc_pkg::FF_MAX;
    end else if (ff_wide < 38'(gfc_pkg::FF_MIN)) begin
      ff_sat = gfc_pkg::FF_MIN;
    end else begin
      ff_sat = ff_wide[gfc_pkg::FF_W-1:0];
    end
  end

endmodule

[test/gravity_feedforward_clamp_checker.sv]
// Checker for the gravity feedforward block: predicts each result and compares it.
module gravity_feedforward_clamp_checker
  import gfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]  wr_data,
  gfc_in_if                  item,
  gfc_out_if                 result,
  output int                 errors,
  output int                 outstanding,
  output int                 clamp_hits
);

  localparam int     ROTATIONS  = 16;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint ANG_PI     = 25736;
  localparam longint ANG_HALF   = 12868;
  localparam longint ANG_TURN   = 51472;
  localparam longint G_DEFAULT  = 2509;
  localparam longint I_MAX      = 30000;
  localparam longint SAT_HI     = 8388607;
  localparam longint SAT_LO     = -8388608;
  localparam longint ARCTAN [ROTATIONS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  cfg_t regs;
  res_t pending_drives [$];

  // Round half up while dropping s fraction bits
  function automatic longint round_off(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Work out drive current, feedforward and clamp flag for one item
  function automatic res_t predict_drive(logic signed [ANGLE_W-1:0] pitch,
                                         logic signed [CUR_W-1:0] base);
    longint ang, x, y, z, dx, dy, cosv, sinv, grav, scale, weight;
    longint horiz, torque, ff, total, lim;
    bit flip;
    res_t r;
    ff = 0;
    if (regs.mass_grams != 0) begin
      grav  = (regs.gravity_accel == 0) ? G_DEFAULT : longint'(regs.gravity_accel);
      scale = (regs.torque_to_current == 0) ? 256 : longint'(regs.torque_to_current);
      // Wrap to +-pi, then fold into +-pi/2 and remember the sign flip
      ang = pitch;
      if (ang > ANG_PI) ang -= ANG_TURN;
      else if (ang < -ANG_PI) ang += ANG_TURN;
      flip = 1'b0;
      if (ang > ANG_HALF) begin
        ang -= ANG_PI;
        flip = 1'b1;
      end else if (ang < -ANG_HALF) begin
        ang += ANG_PI;
        flip = 1'b1;
      end
      // Rotate toward the angle, one micro-rotation per step
      x = GAIN_Q30;
      y = 0;
      z = ang * 131072;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ARCTAN[i];
        end else begin
          x += dx;
          y -= dy;
          z += ARCTAN[i];
        end
      end
      cosv = round_off(x, 15);
      sinv = round_off(y, 15);
      if (flip) begin
        cosv = -cosv;
        sinv = -sinv;
      end
      horiz  = longint'(regs.com_forward) * cosv + longint'(regs.com_upward) * sinv;
      weight = (longint'(regs.mass_grams) * grav + 500) / 1000;
      torque = round_off(-(weight * horiz), 22);
      ff     = round_off(torque * scale, 24);
      if (ff > SAT_HI) ff = SAT_HI;
      else if (ff < SAT_LO) ff = SAT_LO;
    end
    // Add to the command and clamp to the symmetric limit
    lim = (regs.current_limit == 0) ? I_MAX : longint'(regs.current_limit);
    total = longint'(base) + ff;
    r.clamped = 1'b0;
    if (total > lim) begin
      total = lim;
      r.clamped = 1'b1;
    end else if (total < -lim) begin
      total = -lim;
      r.clamped = 1'b1;
    end
    r.drive = total[CUR_W-1:0];
    r.ff    = ff[FF_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs = CFG_RESET;
      pending_drives.delete();
      errors = 0;
      clamp_hits = 0;
    end else begin
      // Track register writes; spare indexes are dropped
      if (wr_en) begin
        case (wr_index)
          REG_MASS:    regs.mass_grams        = wr_data[15:0];
          REG_COM_FWD: regs.com_forward       = wr_data[15:0];
          REG_COM_UP:  regs.com_upward        = wr_data[15:0];
          REG_GRAVITY: regs.gravity_accel     = wr_data[15:0];
          REG_SCALE:   regs.torque_to_current = wr_data[23:0];
          REG_LIMIT:   regs.current_limit     = wr_data[14:0];
          default: ;
        endcase
      end
      // Compare each result transfer with the oldest prediction
      if (result.valid && result.ready) begin
        if (pending_drives.size() == 0) begin
          $error("result transfer with no item waiting for it");
          errors++;
        end else begin
          want = pending_drives.pop_front();
          if (result.drive_current !== want.drive) begin
            $error("drive_current: expected %0d, got %0d", want.drive, result.drive_current);
            errors++;
          end
          if (result.feedforward !== want.ff) begin
            $error("feedforward: expected %0d, got %0d", want.ff, result.feedforward);
            errors++;
          end
          if (result.clamped !== want.clamped) begin
            $error("clamped: expected %0d, got %0d", want.clamped, result.clamped);
            errors++;
          end
          if (want.clamped) clamp_hits++;
        end
      end
      // Predict each item transfer
      if (item.valid && item.ready)
        pending_drives.push_back(predict_drive(item.pitch_angle, item.base_current));
    end
    outstanding = pending_drives.size();
  end

endmodule

[test/gravity_feedforward_clamp_top_tb.sv]
// Testbench top for the gravity feedforward block: stimulus, register setup and verdict.
module gravity_feedforward_clamp_top_tb;
  import gfc_pkg::*;

  localparam logic [INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int ITEMS_PER_CFG = 97;
  localparam int NUM_RANDOM_CFG = 4;
  localparam int NUM_DIRECTED = 21;
  localparam int DIR_PITCH [NUM_DIRECTED] = '{
    0, 25736, -25736, 12868, -12868, 12869, -12869, 25737, -25737, 32767, -32768,
    1, -1, 6434, -6434, 19302, -19302, 16384, -16384, 8192, -8192
  };
  localparam int DIR_BASE [NUM_DIRECTED] = '{
    0, 0, 0, 100, -100, 2999, -2999, 3000, -3000, 32767, -32768,
    3001, -3001, 32767, -32768, 0, 1, -1, 2500, -2500, 12345
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [DATA_W-1:0]  wr_data;
  int                 errors;
  int                 outstanding;
  int                 clamp_hits;
  int                 items_sent = 0;
  int                 cfg_count = 1;
  bit                 quiet = 1'b0;

  gfc_in_if  item();
  gfc_out_if result();

  gravity_feedforward_clamp_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item),
    .result   (result)
  );

  gravity_feedforward_clamp_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .item        (item),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .clamp_hits  (clamp_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts until the quiet stretch
  initial begin
    result.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result.ready <= 1'b1;
      end
    end
  end

  // Offer one item, maybe after an idle burst, and hold it until the transfer
  task automatic send_pitch(input logic signed [ANGLE_W-1:0] pitch,
                            input logic signed [CUR_W-1:0] base);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.pitch_angle  <= pitch;
    item.base_current <= base;
    do begin
      @(negedge clk);
      taken = item.ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic drain_results();
    item.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // Load all six registers while idle, plus writes to the spare indexes
  task automatic program_regs(input logic [DATA_W-1:0] mass, fwd, up, grav, scale, lim);
    drain_results();
    write_reg(REG_MASS, mass);
    write_reg(REG_SPARE_A, DATA_W'($urandom));
    write_reg(REG_COM_FWD, fwd);
    write_reg(REG_COM_UP, up);
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_SCALE, scale);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_SPARE_B, DATA_W'($urandom));
    wr_en <= 1'b0;
    cfg_count++;
  endtask

  function automatic logic signed [ANGLE_W-1:0] rand_pitch();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ANGLE_W'($urandom);
    if (pick == 1) begin
      case ($urandom_range(0, 5))
        0: return ANGLE_W'(25736);
        1: return ANGLE_W'(-25736);
        2: return ANGLE_W'(12868);
        3: return ANGLE_W'(-12868);
        4: return ANGLE_W'(12869);
        default: return ANGLE_W'(-12869);
      endcase
    end
    return ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic signed [CUR_W-1:0] rand_base();
    if ($urandom_range(0, 3) == 0) return CUR_W'($urandom);
    return CUR_W'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pitch(rand_pitch(), rand_base());
  endtask

  initial begin
    rst               <= 1'b1;
    wr_en             <= 1'b0;
    wr_index          <= '0;
    wr_data           <= '0;
    item.valid        <= 1'b0;
    item.pitch_angle  <= '0;
    item.base_current <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset values, with a full pause midway
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      send_pitch(ANGLE_W'(DIR_PITCH[k]), CUR_W'(DIR_BASE[k]));
      if (k == 10) drain_results();
    end
    send_random(ITEMS_PER_CFG);

    // All registers zero: no torque, defaults for gravity, scale and limit
    program_regs(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_random(ITEMS_PER_CFG);

    // Largest values: feedforward saturates; upper data bits set
    program_regs(24'hFFFFFF, 24'hFF7FFF, 24'hFF8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFF7FFF);
    send_random(ITEMS_PER_CFG);

    // Smallest nonzero values, the most negative forward offset and the largest upward offset
    program_regs(24'h000001, 24'h008000, 24'h007FFF, 24'h000001, 24'h000001, 24'h000001);
    send_random(ITEMS_PER_CFG);

    // Random settings; the last one runs with no idling on either side
    for (int c = 0; c < NUM_RANDOM_CFG; c++) begin
      program_regs({8'($urandom), 16'($urandom_range(1, 20000))},
                   DATA_W'($urandom), DATA_W'($urandom),
                   {8'($urandom), 16'($urandom_range(0, 5000))},
                   DATA_W'($urandom_range(0, 2048)),
                   DATA_W'($urandom));
      if (c == NUM_RANDOM_CFG - 1) quiet = 1'b1;
      send_random(ITEMS_PER_CFG);
    end

    // Let the pipeline empty, then watch for stray results
    drain_results();
    repeat (40) @(posedge clk);
    $display("Run sent %0d items over %0d register settings; %0d results hit the clamp.",
             items_sent, cfg_count, clamp_hits);
    if (errors == 0) begin
      $display("PASS gravity_feedforward_clamp_top");
    end else begin
      $display("FAIL gravity_feedforward_clamp_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL gravity_feedforward_clamp_top");
    $finish;
  end

endmodule

[gravity_feedforward_clamp_top.f]
+incdir+rtl
rtl/gfc_pkg.sv
rtl/gfc_if.sv
rtl/gfc_weight.sv
rtl/gfc_cordic.sv
rtl/gfc_scale.sv
rtl/gravity_feedforward_clamp_top.sv
test/gravity_feedforward_clamp_checker.sv
test/gravity_feedforward_clamp_top_tb.sv
